>>> hw/rtl/rlepd_pkg.sv
// ----------------------------------------------------------------------------
// Run-length palette pixel decoder package
// Item types, constants and the control record shared by the decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package rlepd_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam logic [15:0] ALPHA_KEY_RESET = 16'h3D3D;
  localparam logic [7:0] EOF_HEADER = 8'h80;

  localparam logic OP_STREAM = 1'b0;
  localparam logic OP_PALETTE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  stream_byte;
    logic [7:0]  entry_index;
    logic [15:0] entry_color;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic [7:0]  repeat_count;
    logic        skip_pixel;
    logic        end_of_image;
  } out_item_t;

  typedef struct packed {
    logic       emit;
    logic       eoi;
    logic [7:0] count;
  } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/rlepd_ctrl.sv
// ----------------------------------------------------------------------------
// Decoder sequencer
// Tracks the header, run and literal phases and tells whether an item makes a result.
// ----------------------------------------------------------------------------
`default_nettype none

module rlepd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire rlepd_pkg::in_item_t item,
  output rlepd_pkg::ctl_t        ctl
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_RUN     = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;
  localparam logic [1:0] PH_UNUSED  = 2'd3;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] remaining;
  logic [7:0] remaining_next;
  logic [7:0] left;

  always_comb begin
    phase_next = phase;
    remaining_next = remaining;
    ctl = '0;
    left = (remaining == 8'd0) ? 8'd1 : remaining;
    if (item.opcode == rlepd_pkg::OP_STREAM) begin
      unique case (phase)
        PH_RUN: begin
          ctl.emit = 1'b1;
          ctl.count = remaining;
          remaining_next = 8'd0;
          phase_next = PH_HEADER;
        end
        PH_LITERAL: begin
          ctl.emit = 1'b1;
          ctl.count = 8'd1;
          remaining_next = left - 8'd1;
          if (left == 8'd1) begin
            phase_next = PH_HEADER;
          end
        end
        PH_HEADER, PH_UNUSED: begin
          if (item.stream_byte == rlepd_pkg::EOF_HEADER) begin
            ctl.emit = 1'b1;
            ctl.eoi = 1'b1;
            remaining_next = 8'd0;
            phase_next = PH_HEADER;
          end else if (item.stream_byte[7] == 1'b0) begin
            remaining_next = item.stream_byte + 8'd1;
            phase_next = PH_LITERAL;
          end else begin
            remaining_next = 8'(9'd257 - {1'b0, item.stream_byte});
            phase_next = PH_RUN;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      remaining <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      remaining <= remaining_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rlepd_palette.sv
// ----------------------------------------------------------------------------
// Palette memory
// Simple dual-port color table with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rlepd_palette #(
  parameter int DEPTH = rlepd_pkg::PALETTE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [15:0]              wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [15:0]                   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rle_palette_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// Run-length palette pixel decoder
// Decodes run-length coded palette indices into 16-bit pixels with skip flags.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  byte      byte_valid/byte_stall  in_item_t: opcode, stream byte, palette entry
//  pixel     pixel_valid/pixel_stall out_item_t: color, repeat count, skip, end
//  cfg       cfg_valid/cfg_ready    alpha key, 16 bits
//
// One item is taken per cycle while byte_stall is low. A result passes
// through the registered palette read and then the output register.
// Reset clears the phase, the count and the pipeline valids; the palette
// is undefined until written. A stall on the pixel side holds the pipeline,
// and the byte side stalls only when both stages are full.
`default_nettype none

module rle_palette_pixel_decoder_top #(
  parameter int PALETTE_DEPTH = rlepd_pkg::PALETTE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire rlepd_pkg::in_item_t  byte_item,
  output logic                      pixel_valid,
  input  wire logic                 pixel_stall,
  output rlepd_pkg::out_item_t      pixel_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic             accept;
  logic             advance;
  logic             s1_free;
  rlepd_pkg::ctl_t  ctl;
  logic [15:0]      alpha_key;
  logic [15:0]      rd_data;
  logic             wr_en;
  logic             rd_in_range;
  logic             wr_in_range;
  logic             s1_valid;
  logic             s1_eoi;
  logic [7:0]       s1_count;
  logic             s1_in_range;
  logic [15:0]      color;

  assign advance = !pixel_valid || !pixel_stall;
  assign s1_free = !s1_valid || advance;
  assign byte_stall = !s1_free;
  assign accept = byte_valid && s1_free;
  assign cfg_ready = 1'b1;

  assign rd_in_range = {1'b0, byte_item.stream_byte} < 9'(PALETTE_DEPTH);
  assign wr_in_range = {1'b0, byte_item.entry_index} < 9'(PALETTE_DEPTH);
  assign wr_en = accept && (byte_item.opcode == rlepd_pkg::OP_PALETTE) && wr_in_range;

  rlepd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .ctl    (ctl)
  );

  rlepd_palette #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (byte_item.entry_index[AW-1:0]),
    .wr_data (byte_item.entry_color),
    .rd_en   (accept),
    .rd_addr (byte_item.stream_byte[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_key <= rlepd_pkg::ALPHA_KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alpha_key <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept && ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_eoi <= ctl.eoi;
      s1_count <= ctl.count;
      s1_in_range <= rd_in_range;
    end
  end

  assign color = (s1_eoi || !s1_in_range) ? 16'd0 : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance) begin
      pixel_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_item.pixel_color <= color;
      pixel_item.repeat_count <= s1_eoi ? 8'd0 : s1_count;
      pixel_item.skip_pixel <= !s1_eoi && (color == alpha_key);
      pixel_item.end_of_image <= s1_eoi;
    end
  end

  a_eoi_shape: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_item.end_of_image |->
      pixel_item.repeat_count == 8'd0 && !pixel_item.skip_pixel)
    else $error("End result carries a count or a skip flag.");

  a_pixel_count: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_item.end_of_image |-> pixel_item.repeat_count != 8'd0)
    else $error("Pixel result with a zero repeat count.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(s1_valid))
    else $error("Result appeared without a palette read behind it.");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && byte_item.opcode == rlepd_pkg::OP_PALETTE |=> !s1_valid)
    else $error("Palette write produced a result.");

endmodule

`default_nettype wire

>>> tb/rle_palette_pixel_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-length palette pixel decoder testbench
// Loads palette entries and feeds coded streams. Runs, literals and end
// markers are sent under several alpha keys, and both sides idle at random.
// Every pixel item is predicted and compared field by field.
// ----------------------------------------------------------------------------

module rle_palette_pixel_decoder_top_test;

  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;

  localparam logic [1:0] EXPECT_HEADER        = 2'd0;
  localparam logic [1:0] EXPECT_RUN_INDEX     = 2'd1;
  localparam logic [1:0] EXPECT_LITERAL_INDEX = 2'd2;

  class pixel_predictor;
    logic [15:0]          alpha_key;
    logic [1:0]           phase;
    logic [7:0]           remaining;
    logic [15:0]          palette [rlepd_pkg::PALETTE_DEPTH];
    bit                   loaded [rlepd_pkg::PALETTE_DEPTH];
    logic [7:0]           loaded_list [$];
    rlepd_pkg::out_item_t expected_pixels [$];
    int                   failures;
    int                   checked;
    int                   items;
    int                   run_pixels;
    int                   literal_pixels;
    int                   markers;
    int                   transparent;
    int                   palette_loads;

    function new();
      alpha_key = rlepd_pkg::ALPHA_KEY_RESET;
      phase = EXPECT_HEADER;
      remaining = '0;
    endfunction

    function logic [15:0] color_of(logic [7:0] idx);
      return (int'(idx) < rlepd_pkg::PALETTE_DEPTH) ? palette[idx] : 16'h0000;
    endfunction

    function void push_pixel(logic [15:0] color, logic [7:0] count);
      rlepd_pkg::out_item_t px;
      px.pixel_color = color;
      px.repeat_count = count;
      px.skip_pixel = (color == alpha_key);
      px.end_of_image = 1'b0;
      if (px.skip_pixel) transparent++;
      expected_pixels.push_back(px);
    endfunction

    function void take_byte(rlepd_pkg::in_item_t it);
      rlepd_pkg::out_item_t marker;
      logic [7:0] left;
      items++;
      if (it.opcode == rlepd_pkg::OP_PALETTE) begin
        palette_loads++;
        if (int'(it.entry_index) < rlepd_pkg::PALETTE_DEPTH) begin
          palette[it.entry_index] = it.entry_color;
          if (!loaded[it.entry_index]) begin
            loaded[it.entry_index] = 1'b1;
            loaded_list.push_back(it.entry_index);
          end
        end
        return;
      end
      case (phase)
        EXPECT_RUN_INDEX: begin
          run_pixels++;
          push_pixel(color_of(it.stream_byte), remaining);
          remaining = '0;
          phase = EXPECT_HEADER;
        end
        EXPECT_LITERAL_INDEX: begin
          literal_pixels++;
          left = (remaining == 8'd0) ? 8'd1 : remaining;
          push_pixel(color_of(it.stream_byte), 8'd1);
          left = left - 8'd1;
          remaining = left;
          if (left == 8'd0) phase = EXPECT_HEADER;
        end
        default: begin
          if (it.stream_byte == rlepd_pkg::EOF_HEADER) begin
            markers++;
            marker = '0;
            marker.end_of_image = 1'b1;
            expected_pixels.push_back(marker);
            remaining = '0;
            phase = EXPECT_HEADER;
          end else if (it.stream_byte < 8'h80) begin
            remaining = it.stream_byte + 8'd1;
            phase = EXPECT_LITERAL_INDEX;
          end else begin
            remaining = 8'(9'd257 - 9'(it.stream_byte));
            phase = EXPECT_RUN_INDEX;
          end
        end
      endcase
    endfunction

    function void check_pixel(rlepd_pkg::out_item_t got);
      rlepd_pkg::out_item_t want;
      checked++;
      if (expected_pixels.size() == 0) begin
        $error("Unexpected pixel item: color %h, count %0d, skip %0b, end %0b",
               got.pixel_color, got.repeat_count, got.skip_pixel, got.end_of_image);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_color !== want.pixel_color) begin
        $error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
        failures++;
      end
      if (got.repeat_count !== want.repeat_count) begin
        $error("repeat_count: expected %0d, got %0d", want.repeat_count, got.repeat_count);
        failures++;
      end
      if (got.skip_pixel !== want.skip_pixel) begin
        $error("skip_pixel: expected %b, got %b", want.skip_pixel, got.skip_pixel);
        failures++;
      end
      if (got.end_of_image !== want.end_of_image) begin
        $error("end_of_image: expected %b, got %b", want.end_of_image, got.end_of_image);
        failures++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_stall;
  rlepd_pkg::in_item_t  byte_item = '0;
  logic                 pixel_valid;
  logic                 pixel_stall = 1'b0;
  rlepd_pkg::out_item_t pixel_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [15:0]          cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int cycles = 0;
  int stalled_offers = 0;
  int key_settings = 1;

  pixel_predictor predictor = new();

  rle_palette_pixel_decoder_top uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_item  (pixel_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      pixel_stall <= 1'b1;
      hold_left--;
    end else begin
      pixel_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && byte_stall) stalled_offers++;
      if (pixel_valid && !pixel_stall) predictor.check_pixel(pixel_item);
    end
  end

  function automatic rlepd_pkg::in_item_t stream_item(logic [7:0] code);
    rlepd_pkg::in_item_t it;
    it.opcode = rlepd_pkg::OP_STREAM;
    it.stream_byte = code;
    it.entry_index = 8'($urandom);
    it.entry_color = 16'($urandom);
    return it;
  endfunction

  function automatic rlepd_pkg::in_item_t palette_item(logic [7:0] idx, logic [15:0] color);
    rlepd_pkg::in_item_t it;
    it.opcode = rlepd_pkg::OP_PALETTE;
    it.stream_byte = 8'($urandom);
    it.entry_index = idx;
    it.entry_color = color;
    return it;
  endfunction

  function automatic logic [7:0] pick_loaded();
    return predictor.loaded_list[$urandom_range(predictor.loaded_list.size() - 1)];
  endfunction

  task automatic send_item(rlepd_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predictor.take_byte(it);
  endtask

  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (predictor.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(logic [15:0] key);
    cfg_valid <= 1'b1;
    cfg_data <= key;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    predictor.alpha_key = key;
    key_settings++;
  endtask

  task automatic send_random(int count);
    logic [7:0]  code;
    logic [15:0] color;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        case ($urandom_range(9))
          0, 1: color = predictor.alpha_key;
          2: color = 16'h0000;
          3: color = 16'hFFFF;
          default: color = 16'($urandom);
        endcase
        send_item(palette_item(8'($urandom), color));
      end else if (predictor.phase != EXPECT_HEADER) begin
        send_item(stream_item(pick_loaded()));
      end else begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          code = rlepd_pkg::EOF_HEADER;
        end else if (pick < 10) begin
          code = 8'($urandom_range(127));
        end else if (pick < 50) begin
          code = 8'($urandom_range(7));
        end else begin
          code = 8'($urandom_range(255, 129));
        end
        send_item(stream_item(code));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 25;
    recv_stall_pct = 71;

    // Directed part under the reset alpha key.
    send_item(palette_item(8'd0, 16'h0000));
    send_item(palette_item(8'd255, 16'hFFFF));
    send_item(palette_item(8'd1, rlepd_pkg::ALPHA_KEY_RESET));
    send_item(palette_item(8'd128, 16'hA5A5));
    send_item(palette_item(8'd127, 16'h5A5A));
    send_item(stream_item(8'h00));
    send_item(stream_item(8'd0));
    send_item(stream_item(8'h02));
    send_item(stream_item(8'd255));
    send_item(palette_item(8'd2, 16'h1234));
    send_item(stream_item(8'd1));
    send_item(stream_item(8'd2));
    send_item(stream_item(8'h81));
    send_item(palette_item(8'd255, 16'hC3C3));
    send_item(stream_item(8'd255));
    send_item(stream_item(8'hFF));
    send_item(stream_item(8'd1));
    send_item(stream_item(rlepd_pkg::EOF_HEADER));
    send_item(stream_item(8'h00));
    send_item(stream_item(8'd127));
    send_item(stream_item(8'hFE));
    send_item(stream_item(8'd128));
    send_item(stream_item(rlepd_pkg::EOF_HEADER));
    send_item(stream_item(rlepd_pkg::EOF_HEADER));

    wait_idle();
    write_key(16'h0000);
    send_random(310);

    wait_idle();
    send_idle_pct = 71;
    recv_stall_pct = 25;
    write_key(16'hFFFF);
    send_random(310);

    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_key(predictor.palette[pick_loaded()]);
    hold_req = 1'b1;
    while (predictor.phase != EXPECT_HEADER) send_item(stream_item(pick_loaded()));
    send_item(stream_item(8'h7F));
    send_random(310);

    wait_idle();
    $display("Checked %0d pixel items from %0d input items: %0d run, %0d literal,",
             predictor.checked, predictor.items, predictor.run_pixels,
             predictor.literal_pixels);
    $display("%0d end markers, %0d transparent, %0d palette loads, %0d keys, %0d stalls.",
             predictor.markers, predictor.transparent, predictor.palette_loads,
             key_settings, stalled_offers);
    if (predictor.failures == 0 && predictor.expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
